// ===== rtl/utps_pkg.sv =====
package utps_pkg;

  localparam int SEED_W  = 31;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = SEED_W + MULT_W;
  localparam int COORD_W = 32;

  localparam logic [MULT_W-1:0]  PM_MULT = 15'd16807;
  localparam logic [SEED_W-1:0]  PM_MOD  = 31'h7FFF_FFFF;
  localparam logic [SEED_W-1:0]  SEED_RESET = 31'd1;
  localparam logic [COORD_W-1:0] Q31_ONE = 32'h8000_0000;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [1:0] LANE_A = 2'd0;
  localparam logic [1:0] LANE_B = 2'd1;
  localparam logic [1:0] LANE_C = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_FOLD1,
    ST_FOLD2,
    ST_FOLD3,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_valid;
    logic quick;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic       in_ready;
    logic       mul_en;
    logic       red_en;
    logic [1:0] lane;
    logic       fold1;
    logic       fold2;
    logic       fold3;
    logic       deliver;
  } ctl_t;

endpackage

// ===== rtl/utps_if.sv =====
interface utps_in_if;
  import utps_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SEED_W-1:0] seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink (input valid, input cmd, input seed_value, output ready);
endinterface

interface utps_out_if;
  import utps_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_r;
  logic [COORD_W-1:0] coord_s;
  logic [COORD_W-1:0] coord_t;
  logic               seed_error;

  modport source (output valid, output coord_r, output coord_s, output coord_t,
                  output seed_error, input ready);
  modport sink (input valid, input coord_r, input coord_s, input coord_t,
                input seed_error, output ready);
endinterface

// ===== rtl/utps_pm_unit.sv =====
module utps_pm_unit (
  input  logic                        clk,
  input  logic                        mul_en,
  input  logic [utps_pkg::SEED_W-1:0] operand,
  output logic [utps_pkg::SEED_W-1:0] result
);
  import utps_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [MULT_W-1:0]  prod_hi;
  logic [SEED_W-1:0]  prod_lo;
  logic [SEED_W:0]    fold_sum;

  // registered product, reduced on the next cycle
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= operand * PM_MULT;
    end
  end

  // 2^31 == 1 mod 2^31-1
  assign prod_hi  = prod[PROD_W-1:SEED_W];
  assign prod_lo  = prod[SEED_W-1:0];
  assign fold_sum = {1'b0, prod_lo} + {{(SEED_W+1-MULT_W){1'b0}}, prod_hi};

  always_comb begin
    if (fold_sum >= {1'b0, PM_MOD}) begin
      result = SEED_W'(fold_sum - {1'b0, PM_MOD});
    end else begin
      result = fold_sum[SEED_W-1:0];
    end
  end

endmodule

// ===== rtl/utps_ctrl.sv =====
module utps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  utps_pkg::sts_t sts,
  output utps_pkg::ctl_t ctl
);
  import utps_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [1:0] lane;
  logic [1:0] lane_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lane  <= LANE_A;
    end else begin
      state <= state_next;
      lane  <= lane_next;
    end
  end

  always_comb begin
    state_next = state;
    lane_next  = lane;
    unique case (state)
      ST_IDLE: begin
        lane_next = LANE_A;
        if (sts.in_valid) begin
          state_next = sts.quick ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_RED;
      ST_RED: begin
        if (lane == LANE_C) begin
          state_next = ST_FOLD1;
        end else begin
          state_next = ST_MUL;
          lane_next  = lane + 2'd1;
        end
      end
      ST_FOLD1: state_next = ST_FOLD2;
      ST_FOLD2: state_next = ST_FOLD3;
      ST_FOLD3: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.lane     = lane;
    ctl.in_ready = (state == ST_IDLE);
    ctl.mul_en   = (state == ST_MUL);
    ctl.red_en   = (state == ST_RED);
    ctl.fold1    = (state == ST_FOLD1);
    ctl.fold2    = (state == ST_FOLD2);
    ctl.fold3    = (state == ST_FOLD3);
    ctl.deliver  = (state == ST_DONE) && sts.out_free;
  end

endmodule

// ===== rtl/uniform_tetrahedron_point_sampler.sv =====
// channel   dir  payload                                  transaction
// cmd_ch    in   cmd, seed_value                          one command
// point_ch  out  coord_r, coord_s, coord_t, seed_error    one result per command
//
// draw: three seed advances, each a multiply and a reduce step through the one shared
//   31x15 modular multiplier, then fold steps FOLD1 to FOLD3 and the done state, which
//   loads the output register; no new command is taken until the block is idle again
// load, or draw with a zero seed: goes straight from idle to the done state
// reset sets the seed to one and empties the output register
// a stalled result holds the block in its done state; cmd_ch ready stays low
module uniform_tetrahedron_point_sampler (
  input logic       clk,
  input logic       rst,
  utps_in_if.sink   cmd_ch,
  utps_out_if.source point_ch
);
  import utps_pkg::*;

  sts_t sts;
  ctl_t ctl;

  logic [SEED_W-1:0]  seed;
  logic [SEED_W-1:0]  pm_result;
  logic [COORD_W-1:0] a;
  logic [COORD_W-1:0] b;
  logic [COORD_W-1:0] c;
  logic               err;
  logic [COORD_W:0]   sum_ab;
  logic               flag_bc;
  logic               flag_abc;
  logic               out_valid;
  logic               in_fire;

  logic [COORD_W+1:0] f1_ab;
  logic [COORD_W+1:0] f2_ab;
  logic [COORD_W+1:0] f2_bc;
  logic [COORD_W+1:0] f2_abc;
  logic [COORD_W+1:0] f3_abc;
  logic [COORD_W+1:0] one_x;

  assign in_fire      = cmd_ch.valid && ctl.in_ready;
  assign cmd_ch.ready = ctl.in_ready;

  assign sts.in_valid = cmd_ch.valid;
  assign sts.quick    = (cmd_ch.cmd == CMD_LOAD) || (seed == '0);
  assign sts.out_free = !out_valid || point_ch.ready;

  utps_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  utps_pm_unit u_pm (
    .clk     (clk),
    .mul_en  (ctl.mul_en),
    .operand (seed),
    .result  (pm_result)
  );

  assign one_x  = {2'b00, Q31_ONE};
  assign f1_ab  = {2'b00, a} + {2'b00, b};
  assign f2_ab  = {2'b00, a} + {2'b00, b};
  assign f2_bc  = {2'b00, b} + {2'b00, c};
  assign f2_abc = f2_ab + {2'b00, c};
  assign f3_abc = {1'b0, sum_ab} + {2'b00, c};

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (in_fire && (cmd_ch.cmd == CMD_LOAD)) begin
      seed <= (cmd_ch.seed_value == PM_MOD) ? '0 : cmd_ch.seed_value;
    end else if (ctl.red_en) begin
      seed <= pm_result;
    end
  end

  // sample and fold datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a   <= '0;
      b   <= '0;
      c   <= '0;
      err <= (cmd_ch.cmd == CMD_DRAW) && (seed == '0);
    end else if (ctl.red_en) begin
      unique case (ctl.lane)
        LANE_A:  a <= {1'b0, pm_result};
        LANE_B:  b <= {1'b0, pm_result};
        default: c <= {1'b0, pm_result};
      endcase
    end else if (ctl.fold1) begin
      if (f1_ab > one_x) begin
        a <= Q31_ONE - a;
        b <= Q31_ONE - b;
      end
    end else if (ctl.fold2) begin
      sum_ab   <= f2_ab[COORD_W:0];
      flag_bc  <= f2_bc > one_x;
      flag_abc <= f2_abc > one_x;
    end else if (ctl.fold3) begin
      priority if (flag_bc) begin
        c <= Q31_ONE - sum_ab[COORD_W-1:0];
        b <= Q31_ONE - c;
      end else if (flag_abc) begin
        c <= COORD_W'(f3_abc - one_x);
        a <= COORD_W'(one_x - {2'b00, b} - {2'b00, c});
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.deliver) begin
      out_valid <= 1'b1;
    end else if (point_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.deliver) begin
      point_ch.coord_r    <= a;
      point_ch.coord_s    <= b;
      point_ch.coord_t    <= c;
      point_ch.seed_error <= err;
    end
  end

  assign point_ch.valid = out_valid;

endmodule

// ===== rtl/utps_checker.sv =====
module utps_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [utps_pkg::COORD_W-1:0] coord_r,
  input logic [utps_pkg::COORD_W-1:0] coord_s,
  input logic [utps_pkg::COORD_W-1:0] coord_t,
  input logic                         seed_error
);
  import utps_pkg::*;

  logic [COORD_W+1:0] coord_sum;

  assign coord_sum = {2'b00, coord_r} + {2'b00, coord_s} + {2'b00, coord_t};

  // held result keeps valid high
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({coord_r, coord_s, coord_t, seed_error}))
    else $error("result changed while stalled");

  // one command at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && seed_error |-> (coord_r == '0) && (coord_s == '0) && (coord_t == '0))
    else $error("seed error with nonzero coordinates");

  // point lies inside the unit tetrahedron
  a_in_tet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> coord_sum <= {2'b00, Q31_ONE})
    else $error("point outside tetrahedron");

endmodule

bind uniform_tetrahedron_point_sampler utps_checker u_utps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd_ch.valid),
  .in_ready   (cmd_ch.ready),
  .out_valid  (point_ch.valid),
  .out_ready  (point_ch.ready),
  .coord_r    (point_ch.coord_r),
  .coord_s    (point_ch.coord_s),
  .coord_t    (point_ch.coord_t),
  .seed_error (point_ch.seed_error)
);

// ===== dv/tb_uniform_tetrahedron_point_sampler.sv =====
`timescale 1ns / 1ps

module tb_uniform_tetrahedron_point_sampler;
  import utps_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] t;
    logic               err;
  } point_t;

  logic clk;
  logic rst;

  utps_in_if  cmd_if ();
  utps_out_if point_if ();

  uniform_tetrahedron_point_sampler DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_ch   (cmd_if),
    .point_ch (point_if)
  );

  logic [SEED_W-1:0] seed_model;
  point_t            point_q[$];

  int mismatch_cnt = 0;
  int checked_cnt  = 0;
  int draw_cnt     = 0;
  int load_cnt     = 0;
  int zero_draw_cnt = 0;
  int fold_ab_cnt  = 0;
  int fold_bc_cnt  = 0;
  int fold_abc_cnt = 0;

  int tx_gap_max = 0;
  int burst_left = 0;
  logic [1:0] rx_mode = 2'd0;
  logic [7:0] rx_pat  = 8'hFF;
  logic [2:0] rx_phase = 3'd0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // one Park-Miller advance
  function automatic logic [SEED_W-1:0] lehmer_next(input logic [SEED_W-1:0] cur);
    longint unsigned prod;
    prod = 64'(cur) * 64'(PM_MULT);
    return SEED_W'(prod % 64'(PM_MOD));
  endfunction

  function automatic point_t predict_point(input logic cmd, input logic [SEED_W-1:0] value);
    point_t p;
    longint one;
    longint a;
    longint b;
    longint c;
    longint hold;
    one = 64'(Q31_ONE);
    p.r = '0;
    p.s = '0;
    p.t = '0;
    p.err = 1'b0;
    if (cmd == CMD_LOAD) begin
      seed_model = (value == PM_MOD) ? '0 : value;
      load_cnt++;
      return p;
    end
    draw_cnt++;
    if (seed_model == '0) begin
      p.err = 1'b1;
      zero_draw_cnt++;
      return p;
    end
    seed_model = lehmer_next(seed_model);
    a = longint'(seed_model);
    seed_model = lehmer_next(seed_model);
    b = longint'(seed_model);
    seed_model = lehmer_next(seed_model);
    c = longint'(seed_model);
    // fold the unit cube onto the tetrahedron
    if (a + b > one) begin
      a = one - a;
      b = one - b;
      fold_ab_cnt++;
    end
    if (b + c > one) begin
      hold = c;
      c = one - a - b;
      b = one - hold;
      fold_bc_cnt++;
    end else if (a + b + c > one) begin
      hold = c;
      c = a + b + c - one;
      a = one - b - hold;
      fold_abc_cnt++;
    end
    p.r = COORD_W'(a);
    p.s = COORD_W'(b);
    p.t = COORD_W'(c);
    return p;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    point_t want;
    if (!rst && point_if.valid && point_if.ready) begin
      checked_cnt++;
      if (point_q.size() == 0) begin
        log_mismatch($sformatf("unexpected transaction r=%h s=%h t=%h err=%b",
                     point_if.coord_r, point_if.coord_s, point_if.coord_t,
                     point_if.seed_error));
      end else begin
        want = point_q.pop_front();
        if (point_if.coord_r !== want.r || point_if.coord_s !== want.s ||
            point_if.coord_t !== want.t || point_if.seed_error !== want.err) begin
          log_mismatch($sformatf("exp r=%h s=%h t=%h err=%b got r=%h s=%h t=%h err=%b",
                       want.r, want.s, want.t, want.err, point_if.coord_r,
                       point_if.coord_s, point_if.coord_t, point_if.seed_error));
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    rx_phase <= rx_phase + 3'd1;
    case (rx_mode)
      2'd0: begin
        point_if.ready <= 1'b1;
      end
      2'd1: begin
        point_if.ready <= rx_pat[rx_phase];
      end
      default: begin
        point_if.ready <= ($urandom_range(0, 9) < 3);
      end
    endcase
  end

  task automatic set_pace(input int gap_max, input int stall_mode);
    tx_gap_max = gap_max;
    burst_left = $urandom_range(0, 10);
    rx_mode <= 2'(stall_mode);
    rx_pat  <= 8'($urandom) | 8'h01;
  endtask

  task automatic send_cmd(input logic cmd, input logic [SEED_W-1:0] value);
    cmd_if.valid      <= 1'b1;
    cmd_if.cmd        <= cmd;
    cmd_if.seed_value <= value;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    point_q.push_back(predict_point(cmd, value));
    if (tx_gap_max != 0) begin
      if (burst_left == 0) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic test_reset_seed();
    set_pace(0, 0);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_DRAW, '1);
    send_cmd(CMD_DRAW, 31'h2AAA_AAAA);
  endtask

  task automatic test_seed_extremes();
    set_pace(3, 1);
    send_cmd(CMD_LOAD, PM_MOD - 31'd1);
    send_cmd(CMD_DRAW, 31'h5555_5555);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_LOAD, 31'd1);
    send_cmd(CMD_DRAW, '1);
    send_cmd(CMD_LOAD, 31'h5555_5555);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_LOAD, 31'h2AAA_AAAA);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_DRAW, '0);
  endtask

  task automatic test_zero_seed();
    set_pace(0, 2);
    send_cmd(CMD_LOAD, '0);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_DRAW, '1);
    send_cmd(CMD_LOAD, PM_MOD);
    send_cmd(CMD_DRAW, 31'h1234_5678);
    send_cmd(CMD_LOAD, 31'd5);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_LOAD, 31'd0);
    send_cmd(CMD_LOAD, 31'd7);
    send_cmd(CMD_DRAW, '0);
  endtask

  // mostly seeded draw runs, some zero or modulus seeds and stray loads
  task automatic test_random_walk(input int n_items);
    int sent;
    int run_len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 3) == 0) set_pace(0, 0);
        else set_pace($urandom_range(0, 8), $urandom_range(0, 2));
      end
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        send_cmd(CMD_LOAD, SEED_W'($urandom_range(1, 32'h7FFF_FFFE)));
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        repeat (run_len) send_cmd(CMD_DRAW, SEED_W'($urandom));
        sent += run_len + 1;
      end else if (pick < 18) begin
        send_cmd(CMD_LOAD, (pick == 16) ? '0 : PM_MOD);
        run_len = $urandom_range(1, 3);
        repeat (run_len) send_cmd(CMD_DRAW, SEED_W'($urandom));
        sent += run_len + 1;
      end else begin
        send_cmd(CMD_LOAD, SEED_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int waited;
    rst               <= 1'b1;
    cmd_if.valid      <= 1'b0;
    cmd_if.cmd        <= CMD_DRAW;
    cmd_if.seed_value <= '0;
    seed_model = SEED_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_seed();
    test_seed_extremes();
    test_zero_seed();
    test_random_walk(1125);
    cmd_if.valid <= 1'b0;

    waited = 0;
    while (point_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (point_q.size() != 0) begin
      log_mismatch($sformatf("%0d expected transactions never arrived", point_q.size()));
    end

    $display("covered %0d draws (%0d on a zero seed) and %0d seed loads", draw_cnt,
             zero_draw_cnt, load_cnt);
    $display("fold cases a+b=%0d b+c=%0d a+b+c=%0d, %0d results checked, %0d mismatches",
             fold_ab_cnt, fold_bc_cnt, fold_abc_cnt, checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
